/* rtl/nsu_pkg.sv */
// Shared types, constants and helper functions for the normal to spherical UV pipeline.
`timescale 1ns / 1ps
package nsu_pkg;

    localparam int COORD_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 32;
    localparam int CW           = 36;   // CORDIC vector width
    localparam int AW           = 32;   // angle accumulator width, 2^-32 turn
    localparam int QSH          = 32 - COORD_BITS;

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic                 zneg;
        logic                 xpos;
        logic                 zero;
        logic signed [31:0]   yw;
        logic signed [CW-1:0] uxr;
        logic signed [CW-1:0] uyi;
    } t_side;

    typedef struct packed {
        logic valid;
        logic last;
        logic zneg;
        logic xpos;
        logic zero;
    } t_tail;

    function automatic logic [AW-1:0] atan_turn(input int i);
        logic [AW-1:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // Round half up to COORD_BITS fraction bits, clamp to [0, 2^COORD_BITS - 1].
    function automatic logic [15:0] quantize(input logic signed [CW-1:0] t);
        logic [CW-1:0] q;
        logic [CW-1:0] maxv;
        maxv = (CW'(1) << COORD_BITS) - CW'(1);
        if (t < 0) begin
            q = '0;
        end else begin
            q = (CW'(t) + (CW'(1) << (QSH - 1))) >> QSH;
        end
        if (q > maxv) begin
            q = maxv;
        end
        return q[15:0];
    endfunction

endpackage

/* rtl/nsu_sqrt_pipe.sv */
// Pipelined integer square root, one result bit per stage, with sideband data.
`timescale 1ns / 1ps
module nsu_sqrt_pipe
    import nsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [63:0] i_n,
    input  t_side       i_side,
    output logic [31:0] o_root,
    output t_side       o_side
);

    logic [63:0] r_n   [SQRT_STEPS];
    logic [63:0] r_res [SQRT_STEPS];
    t_side       r_side[SQRT_STEPS];

    genvar j;
    generate
        for (j = 0; j < SQRT_STEPS; j++) begin : g_stage
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
            logic [63:0] a_n;
            logic [63:0] a_res;
            logic [63:0] a_sum;
            t_side       a_side;
            logic [63:0] n_n;
            logic [63:0] n_res;

            if (j == 0) begin : g_first
                assign a_n    = i_n;
                assign a_res  = '0;
                assign a_side = i_side;
            end else begin : g_next
                assign a_n    = r_n[j-1];
                assign a_res  = r_res[j-1];
                assign a_side = r_side[j-1];
            end

            always_comb begin
                a_sum = a_res + BIT;
                if (a_n >= a_sum) begin
                    n_n   = a_n - a_sum;
                    n_res = (a_res >> 1) + BIT;
                end else begin
                    n_n   = a_n;
                    n_res = a_res >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side[j].valid <= 1'b0;
                end else if (i_en) begin
                    r_n[j]    <= n_n;
                    r_res[j]  <= n_res;
                    r_side[j] <= a_side;
                end
            end
        end
    endgenerate

    assign o_root = r_res[SQRT_STEPS-1][31:0];
    assign o_side = r_side[SQRT_STEPS-1];

endmodule

/* rtl/nsu_cordic_pipe.sv */
// Pipelined vectoring CORDIC, one rotation per stage, angle in 2^-32 turn.
`timescale 1ns / 1ps
module nsu_cordic_pipe
    import nsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [CW-1:0] i_xr,
    input  logic signed [CW-1:0] i_yi,
    output logic signed [AW-1:0] o_ang
);

    logic signed [CW-1:0] r_xr [CORDIC_STEPS];
    logic signed [CW-1:0] r_yi [CORDIC_STEPS];
    logic signed [AW-1:0] r_ang[CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_stage
            localparam logic signed [AW-1:0] ATN = atan_turn(i);
            logic signed [CW-1:0] a_xr;
            logic signed [CW-1:0] a_yi;
            logic signed [AW-1:0] a_ang;
            logic signed [CW-1:0] n_xr;
            logic signed [CW-1:0] n_yi;
            logic signed [AW-1:0] n_ang;

            if (i == 0) begin : g_first
                assign a_xr  = i_xr;
                assign a_yi  = i_yi;
                assign a_ang = '0;
            end else begin : g_next
                assign a_xr  = r_xr[i-1];
                assign a_yi  = r_yi[i-1];
                assign a_ang = r_ang[i-1];
            end

            // rotate toward the x axis; y above zero counts as positive
            always_comb begin
                if (a_yi > 0) begin
                    n_xr  = a_xr + (a_yi >>> i);
                    n_yi  = a_yi - (a_xr >>> i);
                    n_ang = a_ang + ATN;
                end else begin
                    n_xr  = a_xr - (a_yi >>> i);
                    n_yi  = a_yi + (a_xr >>> i);
                    n_ang = a_ang - ATN;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_xr[i]  <= n_xr;
                    r_yi[i]  <= n_yi;
                    r_ang[i] <= n_ang;
                end
            end
        end
    endgenerate

    assign o_ang = r_ang[CORDIC_STEPS-1];

endmodule

/* rtl/normal_to_spherical_uv.sv */
// Top level: unit normal in, equirectangular texture coordinate out.
// Usage:
//   Input stream (s_axis): one transaction per vertex normal; tdata carries
//   norm_x, norm_y, norm_z (signed Q1.15), tlast marks the final vertex.
//   Output stream (m_axis): one transaction per vertex; tdata carries
//   tex_u and tex_v (unsigned Q0.16, saturated), tlast copies the input mark.
//   The pipeline is one input register, 32 square-root stages (one
//   root bit each, for the cosine of the latitude), 16 CORDIC stages that
//   run the longitude and latitude angles side by side, and one output
//   register that rounds and saturates.
//   Throughput is one vertex per cycle while the pipeline is not held; the
//   depth is set by the bit-per-stage square root in front of the latitude CORDIC.
//   Reset (synchronous, active low) empties the pipeline; tready rises in the
//   first cycle after reset and results never appear out of reset.
//   When the receiver drops tready with a result waiting, the whole pipeline
//   holds and s_axis tready falls; nothing is lost or repeated. While the
//   output register is empty the pipeline advances regardless of tready.
`timescale 1ns / 1ps
module normal_to_spherical_uv
    import nsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // norm_x[15:0], norm_y[31:16], norm_z[47:32]
    input  logic        i_s_axis_tlast,   // is_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // tex_u[15:0], tex_v[31:16]
    output logic        o_m_axis_tlast    // last_coord
);

    logic en;

    logic signed [15:0]   in_x;
    logic signed [15:0]   in_y;
    logic signed [15:0]   in_z;
    logic signed [31:0]   ysq;
    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ze;
    t_side                n_front;
    logic [63:0]          n_rad;

    t_side       r_front;
    logic [63:0] r_rad;

    logic [31:0] root;
    t_side       sq_side;

    logic signed [AW-1:0] ang_u;
    logic signed [AW-1:0] ang_v;
    t_tail                r_tail[CORDIC_STEPS];

    logic signed [CW-1:0] tu;
    logic signed [CW-1:0] tv;
    logic signed [CW-1:0] base;
    t_tail                tl;

    logic        r_out_valid;
    logic [15:0] r_tex_u;
    logic [15:0] r_tex_v;
    logic        r_out_last;

    // advance whenever the output slot is free or being emptied
    assign en              = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = en && i_rst_n;

    assign in_x = i_s_axis_tdata[15:0];
    assign in_y = i_s_axis_tdata[31:16];
    assign in_z = i_s_axis_tdata[47:32];

    always_comb begin
        ysq            = in_y * in_y;
        xe             = CW'(in_x);
        ze             = CW'(in_z);
        n_front.valid  = i_s_axis_tvalid;
        n_front.last   = i_s_axis_tlast;
        n_front.zneg   = in_z < 0;
        n_front.xpos   = in_x >= 0;
        n_front.zero   = (in_x == 0) && (in_z == 0);
        n_front.yw     = {in_y, 16'd0};
        // fold the left half-plane onto the right with a half-turn rotation
        n_front.uxr    = (n_front.zneg ? -ze : ze) <<< 16;
        n_front.uyi    = (n_front.zneg ? -xe : xe) <<< 16;
        n_rad          = (64'd1 << 62) - {ysq, 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (en) begin
            r_front <= n_front;
            r_rad   <= n_rad;
        end
    end

    nsu_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_n     (r_rad),
        .i_side  (r_front),
        .o_root  (root),
        .o_side  (sq_side)
    );

    nsu_cordic_pipe u_cordic_u (
        .i_clk (i_clk),
        .i_en  (en),
        .i_xr  (sq_side.uxr),
        .i_yi  (sq_side.uyi),
        .o_ang (ang_u)
    );

    nsu_cordic_pipe u_cordic_v (
        .i_clk (i_clk),
        .i_en  (en),
        .i_xr  (CW'({1'b0, root})),
        .i_yi  (CW'(sq_side.yw)),
        .o_ang (ang_v)
    );

    genvar k;
    generate
        for (k = 0; k < CORDIC_STEPS; k++) begin : g_tail
            t_tail a_tail;
            if (k == 0) begin : g_first
                assign a_tail = '{valid: sq_side.valid, last: sq_side.last,
                                  zneg: sq_side.zneg, xpos: sq_side.xpos,
                                  zero: sq_side.zero};
            end else begin : g_next
                assign a_tail = r_tail[k-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tail[k].valid <= 1'b0;
                end else if (en) begin
                    r_tail[k] <= a_tail;
                end
            end
        end
    endgenerate

    assign tl = r_tail[CORDIC_STEPS-1];

    always_comb begin
        if (tl.zneg) begin
            base = tl.xpos ? (CW'(1) <<< 31) : -(CW'(1) <<< 31);
        end else begin
            base = '0;
        end
        if (tl.zero) begin
            tu = CW'(1) <<< 31;
        end else begin
            tu = (CW'(1) <<< 31) + base + CW'(ang_u);
        end
        tv = (CW'(1) <<< 31) - (CW'(ang_v) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= tl.valid;
            r_tex_u     <= quantize(tu);
            r_tex_v     <= quantize(tv);
            r_out_last  <= tl.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_tex_v, r_tex_u};
    assign o_m_axis_tlast  = r_out_last;

endmodule

/* bench/normal_to_spherical_uv_tb.sv */
// Testbench for normal_to_spherical_uv: directed table plus random normals vs. predictor.
`timescale 1ns / 1ps
module normal_to_spherical_uv_tb
    import nsu_pkg::*;
();

    localparam int LATENCY    = 50;
    localparam int N_RANDOM   = 1630;
    localparam int WATCHDOG   = 2000;
    localparam int CALM_TAIL  = 200;

    typedef struct packed {
        logic        last;
        logic [15:0] v;
        logic [15:0] u;
    } t_coord;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        last;
        logic        has_exp;
        logic [15:0] u_exp;
        logic [15:0] v_exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    normal_to_spherical_uv i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    t_coord coord_q[$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     calm;

    function automatic longint arctan_step(input int i);
        case (i)
            0:  return 64'h20000000;
            1:  return 64'h12E4051E;
            2:  return 64'h09FB385B;
            3:  return 64'h051111D4;
            4:  return 64'h028B0D43;
            5:  return 64'h0145D7E1;
            6:  return 64'h00A2F61E;
            7:  return 64'h00517C55;
            8:  return 64'h0028BE53;
            9:  return 64'h00145F2F;
            10: return 64'h000A2F98;
            11: return 64'h000517CC;
            12: return 64'h00028BE6;
            13: return 64'h000145F3;
            14: return 64'h0000A2FA;
            15: return 64'h0000517D;
            16: return 64'h000028BE;
            17: return 64'h0000145F;
            18: return 64'h00000A30;
            19: return 64'h00000518;
            20: return 64'h0000028C;
            21: return 64'h00000146;
            22: return 64'h000000A3;
            23: return 64'h00000051;
            24: return 64'h00000029;
            25: return 64'h00000014;
            26: return 64'h0000000A;
            27: return 64'h00000005;
            28: return 64'h00000003;
            29: return 64'h00000001;
            30: return 64'h00000001;
            default: return 64'h0;
        endcase
    endfunction

    // Vectoring rotation toward the x axis; returns the angle in 2^-32 turn.
    function automatic longint vector_angle(input longint xr, input longint yi);
        longint ang, dx, dy;
        ang = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = yi >>> i;
            dy = xr >>> i;
            if (yi > 0) begin
                xr += dx;
                yi -= dy;
                ang += arctan_step(i);
            end else begin
                xr -= dx;
                yi += dy;
                ang -= arctan_step(i);
            end
        end
        return ang;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] turn_to_coord(input longint t);
        logic [63:0] q;
        if (t < 0) t = 0;
        q = (64'(t) + (64'd1 << (31 - COORD_BITS))) >> (32 - COORD_BITS);
        if (q > (64'd1 << COORD_BITS) - 1) q = (64'd1 << COORD_BITS) - 1;
        return q[15:0];
    endfunction

    function automatic t_coord sphere_coord(input logic [15:0] nx, input logic [15:0] ny,
                                            input logic [15:0] nz, input logic lst);
        longint x, y, z, au, av, yw, base;
        logic [63:0] c;
        t_coord r;
        x = longint'($signed(nx));
        y = longint'($signed(ny));
        z = longint'($signed(nz));
        au = 0;
        if (!(x == 0 && z == 0)) begin
            base = 0;
            if (z < 0) begin
                base = (x >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
                z = -z;
                x = -x;
            end
            au = base + vector_angle(z * 65536, x * 65536);
        end
        yw = y * 65536;
        c = root_floor((64'd1 << 62) - 64'(yw * yw));
        av = vector_angle(longint'(c), yw);
        r.u = turn_to_coord((64'sd1 <<< 31) + au);
        r.v = turn_to_coord((64'sd1 <<< 31) - 2 * av);
        r.last = lst;
        return r;
    endfunction

    // Directed rows; expected values typed only where obvious.
    t_row vectors[] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h8000, 16'h8000},
        '{16'h0000, 16'h8000, 16'h8000, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF},
        '{16'h0000, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'h7FFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'h8000, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0, 16'h0},
        '{16'h0000, 16'h0000, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0, 16'h0, 16'h0},
        '{16'h0001, 16'h0001, 16'hFFFF, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'hFFFF, 16'h4000, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'h5A82, 16'hC000, 16'h5A82, 1'b1, 1'b0, 16'h0, 16'h0},
        '{16'hA57E, 16'h2000, 16'hA57E, 1'b0, 1'b0, 16'h0, 16'h0},
        '{16'h0000, 16'h8001, 16'h0001, 1'b0, 1'b0, 16'h0, 16'h0}
    };

    task automatic send_normal(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input logic lst,
                               input bit typed, input logic [15:0] ue,
                               input logic [15:0] ve);
        t_coord e;
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  <= {z, y, x};
        i_s_axis_tlast  <= lst;
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        e = sphere_coord(x, y, z, lst);
        if (typed && (e.u != ue || e.v != ve))
            $display("%0t predictor disagrees with table: exp u=%h v=%h got u=%h v=%h",
                     $time, ue, ve, e.u, e.v);
        if (typed) begin
            e.u = ue;
            e.v = ve;
        end
        coord_q = {coord_q, e};
        @(negedge i_clk);
    endtask

    // Receiver stalls and result check.
    initial begin
        int stall;
        t_coord got, e;
        i_m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 13);
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if (o_m_axis_tvalid) begin
                got = {o_m_axis_tlast, o_m_axis_tdata[31:16], o_m_axis_tdata[15:0]};
                if (coord_q.size() == 0) begin
                    $display("%0t unexpected result u=%h v=%h last=%b",
                             $time, got.u, got.v, got.last);
                    errors++;
                end else begin
                    e = coord_q.pop_front();
                    if (got !== e) begin
                        $display("%0t mismatch: exp u=%h v=%h last=%b got u=%h v=%h last=%b",
                                 $time, e.u, e.v, e.last, got.u, got.v, got.last);
                        errors++;
                    end
                end
            end
            @(negedge i_clk);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("normal_to_spherical_uv_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int drain;
        logic [15:0] rx, ry, rz, s;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tlast = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (vectors[k])
            send_normal(vectors[k].x, vectors[k].y, vectors[k].z, vectors[k].last,
                        vectors[k].has_exp, vectors[k].u_exp, vectors[k].v_exp);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= N_RANDOM - CALM_TAIL) calm = 1'b1;
            case ($urandom_range(0, 3))
                0: begin
                    // raw noise over the full field range
                    rx = 16'($urandom); ry = 16'($urandom); rz = 16'($urandom);
                end
                1: begin
                    // axis and sign corners
                    s  = 16'($urandom_range(0, 3));
                    rx = (s == 0) ? 16'h0 : (s == 1) ? 16'h7FFF : (s == 2) ? 16'h8000 :
                         16'($urandom);
                    s  = 16'($urandom_range(0, 3));
                    rz = (s == 0) ? 16'h0 : (s == 1) ? 16'h7FFF : (s == 2) ? 16'h8000 :
                         16'($urandom);
                    s  = 16'($urandom_range(0, 2));
                    ry = (s == 0) ? 16'h8000 : (s == 1) ? 16'h7FFF : 16'($urandom);
                end
                default: begin
                    // random components in [-23170, 23170], not normalized to unit length
                    rx = 16'($urandom_range(0, 46340) - 23170);
                    rz = 16'($urandom_range(0, 46340) - 23170);
                    ry = 16'($urandom_range(0, 46340) - 23170);
                end
            endcase
            send_normal(rx, ry, rz, 1'($urandom_range(0, 1)), 1'b0, 16'h0, 16'h0);
        end
        i_s_axis_tvalid <= 1'b0;

        drain = 0;
        while (coord_q.size() != 0 && drain < 100000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (LATENCY + 10) @(negedge i_clk);
        if (errors == 0 && coord_q.size() == 0)
            $display("normal_to_spherical_uv_tb: done, clean");
        else
            $display("normal_to_spherical_uv_tb: done, errors");
        $finish;
    end

endmodule
